// ===== hdl/lbco_pkg.sv =====
// lbco_pkg: shared types and constants for the level border colour overlay
// no dependencies; imported by the top level and by its checker
`default_nettype none

package lbco_pkg;

   // configuration register indexes on the csr port
   typedef enum logic [2:0] {
      REG_YELLOW_LEVEL  = 3'd0,
      REG_ORANGE_LEVEL  = 3'd1,
      REG_RED_LEVEL     = 3'd2,
      REG_GREY_COLOUR   = 3'd3,
      REG_YELLOW_COLOUR = 3'd4,
      REG_ORANGE_COLOUR = 3'd5,
      REG_RED_COLOUR    = 3'd6,
      REG_BORDER_WIDTH  = 3'd7
   } reg_index_type;

   // blink speed classes
   typedef enum logic [1:0] {
      BLINK_NONE   = 2'd0,
      BLINK_SLOW   = 2'd1,
      BLINK_MEDIUM = 2'd2,
      BLINK_FAST   = 2'd3
   } blink_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } colour_type;

   localparam int unsigned LEVEL_W  = 7;
   localparam int unsigned COLOUR_W = 24;
   localparam int unsigned BORDER_W = 5;
   localparam int unsigned CSR_W    = 24;

   // length of each blend ramp in dB
   localparam logic [7:0] BLEND_SPAN = 8'd5;
   // ceil(2^18 / 5): exact floor division by five for numerators up to 1275
   localparam logic [26:0] RECIP5 = 27'd52429;

   localparam logic [LEVEL_W-1:0]  YELLOW_LEVEL_RST  = 7'd80;
   localparam logic [LEVEL_W-1:0]  ORANGE_LEVEL_RST  = 7'd90;
   localparam logic [LEVEL_W-1:0]  RED_LEVEL_RST     = 7'd95;
   localparam logic [COLOUR_W-1:0] GREY_COLOUR_RST   = 24'h202020;
   localparam logic [COLOUR_W-1:0] YELLOW_COLOUR_RST = 24'h606000;
   localparam logic [COLOUR_W-1:0] ORANGE_COLOUR_RST = 24'h602000;
   localparam logic [COLOUR_W-1:0] RED_COLOUR_RST    = 24'h600000;
   localparam logic [BORDER_W-1:0] BORDER_WIDTH_RST  = 5'd1;

endpackage : lbco_pkg

`default_nettype wire

// ===== hdl/level_border_colour_overlay.sv =====
// level_border_colour_overlay: border band test and level driven colour per pixel
// depends on lbco_pkg
`default_nettype none
//
//  channel  direction  handshake              payload
//  req      in         req_valid / req_stall  column, row, level_db, show
//  rsp      out        rsp_valid / rsp_stall  border_pixel, red, green, blue, blink_speed
//  csr      in         csr_write              csr_index, csr_data
//
//  one request per clock while req_stall is low; the edge that takes a request loads the input
//  register, then the result register loads from it whenever rsp_stall does not hold it
//  synchronous reset clears the pipeline valids and loads the register defaults
//  req_stall is high during reset and while a stalled result blocks a full input stage
//  rsp_stall holds the result register; the input stage still fills behind it

module level_border_colour_overlay
   import lbco_pkg::*;
#(
   parameter int WIDTH  = 64,
   parameter int HEIGHT = 32
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [5:0]          req_column,
   input  wire logic [4:0]          req_row,
   input  wire logic [LEVEL_W-1:0]  req_level_db,
   input  wire logic                req_show,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic                     rsp_border_pixel,
   output logic [7:0]               rsp_red,
   output logic [7:0]               rsp_green,
   output logic [7:0]               rsp_blue,
   output logic [1:0]               rsp_blink_speed,
   input  wire logic                csr_write,
   input  wire logic [2:0]          csr_index,
   input  wire logic [CSR_W-1:0]    csr_data
);

   localparam logic [8:0] WIDTH_L  = 9'(WIDTH);
   localparam logic [8:0] HEIGHT_L = 9'(HEIGHT);

   function automatic logic [7:0] blend_chan(input logic [7:0] c1, input logic [7:0] c2,
                                             input logic [2:0] k);
      logic [10:0] num;
      logic [26:0] prod;
      logic [2:0]  kc;
      kc   = 3'(BLEND_SPAN) - k;
      num  = 11'(c1) * 11'(kc) + 11'(c2) * 11'(k);
      prod = 27'(num) * RECIP5;
      return prod[25:18];
   endfunction

   // configuration registers
   logic [LEVEL_W-1:0]  yellow_level_ff, orange_level_ff, red_level_ff;
   logic [COLOUR_W-1:0] grey_colour_ff, yellow_colour_ff, orange_colour_ff, red_colour_ff;
   logic [BORDER_W-1:0] border_width_ff;

   // input stage
   logic                s1_valid_ff;
   logic [5:0]          s1_column_ff;
   logic [4:0]          s1_row_ff;
   logic [LEVEL_W-1:0]  s1_level_ff;
   logic                s1_show_ff;

   // result stage
   logic                rsp_valid_ff;
   logic                rsp_border_pixel_ff, rsp_border_pixel_in;
   colour_type          rsp_colour_ff, rsp_colour_in;
   blink_type           rsp_blink_ff, rsp_blink_in;

   logic s2_load, s1_load;

   assign s2_load   = !rsp_valid_ff || !rsp_stall;
   assign s1_load   = !s1_valid_ff || s2_load;
   assign req_stall = reset || !s1_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         yellow_level_ff  <= YELLOW_LEVEL_RST;
         orange_level_ff  <= ORANGE_LEVEL_RST;
         red_level_ff     <= RED_LEVEL_RST;
         grey_colour_ff   <= GREY_COLOUR_RST;
         yellow_colour_ff <= YELLOW_COLOUR_RST;
         orange_colour_ff <= ORANGE_COLOUR_RST;
         red_colour_ff    <= RED_COLOUR_RST;
         border_width_ff  <= BORDER_WIDTH_RST;
      end else if (csr_write) begin
         case (reg_index_type'(csr_index))
            REG_YELLOW_LEVEL:  yellow_level_ff  <= csr_data[LEVEL_W-1:0];
            REG_ORANGE_LEVEL:  orange_level_ff  <= csr_data[LEVEL_W-1:0];
            REG_RED_LEVEL:     red_level_ff     <= csr_data[LEVEL_W-1:0];
            REG_GREY_COLOUR:   grey_colour_ff   <= csr_data[COLOUR_W-1:0];
            REG_YELLOW_COLOUR: yellow_colour_ff <= csr_data[COLOUR_W-1:0];
            REG_ORANGE_COLOUR: orange_colour_ff <= csr_data[COLOUR_W-1:0];
            REG_RED_COLOUR:    red_colour_ff    <= csr_data[COLOUR_W-1:0];
            REG_BORDER_WIDTH: begin
               // a zero thickness is ignored
               if (csr_data[BORDER_W-1:0] != '0) begin
                  border_width_ff <= csr_data[BORDER_W-1:0];
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_load) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load && req_valid) begin
         s1_column_ff <= req_column;
         s1_row_ff    <= req_row;
         s1_level_ff  <= req_level_db;
         s1_show_ff   <= req_show;
      end
   end

   // border band test
   logic [8:0] x9, y9, right9, bottom9, min_a, min_b, min_all;
   logic       in_frame;

   always_comb begin
      x9       = {3'b000, s1_column_ff};
      y9       = {4'b0000, s1_row_ff};
      in_frame = (x9 < WIDTH_L) && (y9 < HEIGHT_L);
      right9   = WIDTH_L - 9'd1 - x9;
      bottom9  = HEIGHT_L - 9'd1 - y9;
      min_a    = (x9 < y9) ? x9 : y9;
      min_b    = (right9 < bottom9) ? right9 : bottom9;
      min_all  = (min_a < min_b) ? min_a : min_b;
      rsp_border_pixel_in = s1_show_ff && in_frame && (min_all < {4'b0000, border_width_ff});
   end

   // colour zone and blend; flat zones blend a colour with itself
   logic [7:0]          lv8, lv_p5, y8, o8, r8;
   logic [COLOUR_W-1:0] c1, c2;
   logic [2:0]          k;

   always_comb begin
      lv8   = {1'b0, s1_level_ff};
      lv_p5 = lv8 + BLEND_SPAN;
      y8    = {1'b0, yellow_level_ff};
      o8    = {1'b0, orange_level_ff};
      r8    = {1'b0, red_level_ff};
      c1    = red_colour_ff;
      c2    = red_colour_ff;
      k     = 3'd0;
      if (lv_p5 < y8) begin
         c1 = grey_colour_ff;
         c2 = grey_colour_ff;
      end else if (lv8 < y8) begin
         c1 = grey_colour_ff;
         c2 = yellow_colour_ff;
         k  = 3'(lv_p5 - y8);
      end else if (lv_p5 < o8) begin
         c1 = yellow_colour_ff;
         c2 = yellow_colour_ff;
      end else if (lv8 < o8) begin
         c1 = yellow_colour_ff;
         c2 = orange_colour_ff;
         k  = 3'(lv_p5 - o8);
      end else if (lv_p5 < r8) begin
         c1 = orange_colour_ff;
         c2 = orange_colour_ff;
      end else if (lv8 < r8) begin
         c1 = orange_colour_ff;
         c2 = red_colour_ff;
         k  = 3'(lv_p5 - r8);
      end
      rsp_colour_in.red   = blend_chan(c1[23:16], c2[23:16], k);
      rsp_colour_in.green = blend_chan(c1[15:8], c2[15:8], k);
      rsp_colour_in.blue  = blend_chan(c1[7:0], c2[7:0], k);

      if (lv8 >= y8 && lv8 < o8) begin
         rsp_blink_in = BLINK_SLOW;
      end else if (lv8 >= o8 && lv8 < r8) begin
         rsp_blink_in = BLINK_MEDIUM;
      end else if (lv8 >= r8) begin
         rsp_blink_in = BLINK_FAST;
      end else begin
         rsp_blink_in = BLINK_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s2_load) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_load && s1_valid_ff) begin
         rsp_border_pixel_ff <= rsp_border_pixel_in;
         rsp_colour_ff       <= rsp_colour_in;
         rsp_blink_ff        <= rsp_blink_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_border_pixel = rsp_border_pixel_ff;
   assign rsp_red          = rsp_colour_ff.red;
   assign rsp_green        = rsp_colour_ff.green;
   assign rsp_blue         = rsp_colour_ff.blue;
   assign rsp_blink_speed  = rsp_blink_ff;

endmodule : level_border_colour_overlay

`default_nettype wire

// ===== hdl/lbco_checker.sv =====
// lbco_checker: port level checks on the overlay pipeline timing and flow control
// depends on lbco_pkg; bound to level_border_colour_overlay below
`default_nettype none

module lbco_checker
   import lbco_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_stall,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire logic               rsp_border_pixel,
   input wire logic [7:0]         rsp_red,
   input wire logic [7:0]         rsp_green,
   input wire logic [7:0]         rsp_blue,
   input wire logic [1:0]         rsp_blink_speed,
   input wire logic               csr_write,
   input wire logic [2:0]         csr_index,
   input wire logic [CSR_W-1:0]   csr_data
);

   // a stalled result holds still
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_border_pixel) && $stable(rsp_red)
         && $stable(rsp_green) && $stable(rsp_blue) && $stable(rsp_blink_speed))
      else $error("result changed while stalled");

   // requests only back up behind a stalled result
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || !rsp_stall) |-> !req_stall)
      else $error("request stalled with the result side free");

   // a taken request is offered as a result when the result side is free in the cycle after it is taken
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 (!rsp_valid || !rsp_stall) |=> rsp_valid)
      else $error("result missing after request");

   // configuration writes happen only while the pipeline is not blocked behind a stalled result
   a_csr_idle: assert property (@(posedge clock) disable iff (reset)
      csr_write |-> !rsp_valid || !rsp_stall || !req_stall)
      else $error("configuration write with a blocked pipeline");

   // a register write carries a known index and value
   a_csr_known: assert property (@(posedge clock) disable iff (reset)
      csr_write |-> !$isunknown({csr_index, csr_data}))
      else $error("configuration write with unknown index or data");

endmodule : lbco_checker

bind level_border_colour_overlay lbco_checker u_lbco_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_border_pixel (rsp_border_pixel),
   .rsp_red          (rsp_red),
   .rsp_green        (rsp_green),
   .rsp_blue         (rsp_blue),
   .rsp_blink_speed  (rsp_blink_speed),
   .csr_write        (csr_write),
   .csr_index        (csr_index),
   .csr_data         (csr_data)
);

`default_nettype wire

// ===== dv/level_border_colour_overlay_tb.sv =====
`timescale 1ns / 100ps
// level_border_colour_overlay_tb: self-checking bench for the border overlay, one file
// drives pixel requests and csr writes, predicts border flag, colour and blink per request
// depends on lbco_pkg and level_border_colour_overlay

module level_border_colour_overlay_tb
   import lbco_pkg::*;
();

   localparam int FRAME_W          = 64;
   localparam int FRAME_H          = 32;
   localparam int PHASES           = 10;
   localparam int PIXELS_PER_PHASE = 160;
   localparam int IDLE_PERCENT     = 36;
   localparam int HOLD_CYCLES      = 300;
   localparam int DRAIN_CYCLES     = 8;
   localparam int NUM_REGS         = 8;
   localparam int DIRECTED_ROWS    = 18;

   typedef struct packed {
      logic [5:0]         column;
      logic [4:0]         row;
      logic [LEVEL_W-1:0] level_db;
      logic               show;
   } pixel_req_type;

   typedef struct packed {
      logic       border;
      colour_type colour;
      blink_type  blink;
   } pixel_result_type;

   typedef struct packed {
      pixel_req_type    px;
      logic             typed;
      pixel_result_type want;
   } directed_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [5:0]         req_column = '0;
   logic [4:0]         req_row = '0;
   logic [LEVEL_W-1:0] req_level_db = '0;
   logic               req_show = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_border_pixel;
   logic [7:0]         rsp_red;
   logic [7:0]         rsp_green;
   logic [7:0]         rsp_blue;
   logic [1:0]         rsp_blink_speed;
   logic               csr_write = 1'b0;
   logic [2:0]         csr_index = '0;
   logic [CSR_W-1:0]   csr_data = '0;

   // predictor copy of the registers
   logic [LEVEL_W-1:0]  yellow_db = YELLOW_LEVEL_RST;
   logic [LEVEL_W-1:0]  orange_db = ORANGE_LEVEL_RST;
   logic [LEVEL_W-1:0]  red_db = RED_LEVEL_RST;
   colour_type          grey_rgb = GREY_COLOUR_RST;
   colour_type          yellow_rgb = YELLOW_COLOUR_RST;
   colour_type          orange_rgb = ORANGE_COLOUR_RST;
   colour_type          red_rgb = RED_COLOUR_RST;
   logic [BORDER_W-1:0] band_width = BORDER_WIDTH_RST;

   pixel_result_type expected_pixels[$];
   logic [CSR_W-1:0] reg_image [NUM_REGS];
   int               mismatch_count = 0;
   bit               steady = 1'b0;
   bit               hold_pending = 1'b0;

   // defaults after reset: typed rows are read straight off the zone table
   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{'{6'd0,  5'd0,  7'd0,   1'b1}, 1'b1, '{1'b1, 24'h202020, BLINK_NONE}},
      '{'{6'd63, 5'd31, 7'd127, 1'b1}, 1'b1, '{1'b1, 24'h600000, BLINK_FAST}},
      '{'{6'd32, 5'd16, 7'd50,  1'b1}, 1'b1, '{1'b0, 24'h202020, BLINK_NONE}},
      '{'{6'd32, 5'd0,  7'd80,  1'b0}, 1'b1, '{1'b0, 24'h606000, BLINK_SLOW}},
      '{'{6'd1,  5'd1,  7'd90,  1'b1}, 1'b1, '{1'b0, 24'h602000, BLINK_MEDIUM}},
      '{'{6'd62, 5'd30, 7'd95,  1'b1}, 1'b1, '{1'b0, 24'h600000, BLINK_FAST}},
      '{'{6'd0,  5'd16, 7'd74,  1'b1}, 1'b1, '{1'b1, 24'h202020, BLINK_NONE}},
      '{'{6'd10, 5'd31, 7'd127, 1'b1}, 1'b1, '{1'b1, 24'h600000, BLINK_FAST}},
      '{'{6'd42, 5'd21, 7'd42,  1'b1}, 1'b1, '{1'b0, 24'h202020, BLINK_NONE}},
      '{'{6'd63, 5'd5,  7'd89,  1'b0}, 1'b0, '{1'b0, 24'h000000, BLINK_NONE}},
      '{'{6'd20, 5'd0,  7'd75,  1'b1}, 1'b0, '{1'b0, 24'h000000, BLINK_NONE}},
      '{'{6'd40, 5'd31, 7'd77,  1'b1}, 1'b0, '{1'b0, 24'h000000, BLINK_NONE}},
      '{'{6'd5,  5'd20, 7'd79,  1'b1}, 1'b0, '{1'b0, 24'h000000, BLINK_NONE}},
      '{'{6'd63, 5'd0,  7'd85,  1'b1}, 1'b0, '{1'b0, 24'h000000, BLINK_NONE}},
      '{'{6'd0,  5'd31, 7'd87,  1'b1}, 1'b0, '{1'b0, 24'h000000, BLINK_NONE}},
      '{'{6'd31, 5'd15, 7'd92,  1'b1}, 1'b0, '{1'b0, 24'h000000, BLINK_NONE}},
      '{'{6'd33, 5'd16, 7'd94,  1'b1}, 1'b0, '{1'b0, 24'h000000, BLINK_NONE}},
      '{'{6'd21, 5'd10, 7'd85,  1'b0}, 1'b0, '{1'b0, 24'h000000, BLINK_NONE}}
   };

   level_border_colour_overlay #(
      .WIDTH (FRAME_W),
      .HEIGHT(FRAME_H)
   ) uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_column      (req_column),
      .req_row         (req_row),
      .req_level_db    (req_level_db),
      .req_show        (req_show),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_border_pixel(rsp_border_pixel),
      .rsp_red         (rsp_red),
      .rsp_green       (rsp_green),
      .rsp_blue        (rsp_blue),
      .rsp_blink_speed (rsp_blink_speed),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #2 clock = ~clock;

   function automatic logic [7:0] blend_byte(logic [7:0] from_c, logic [7:0] to_c, int k);
      int num;
      num = 5 * int'(from_c) + (int'(to_c) - int'(from_c)) * k;
      if (num < 0) num = 0;
      num = num / 5;
      if (num > 255) num = 255;
      return 8'(num);
   endfunction

   function automatic colour_type blend_rgb(colour_type a, colour_type b, int k);
      colour_type c;
      c.red   = blend_byte(a.red, b.red, k);
      c.green = blend_byte(a.green, b.green, k);
      c.blue  = blend_byte(a.blue, b.blue, k);
      return c;
   endfunction

   function automatic pixel_result_type predict_pixel(pixel_req_type px);
      pixel_result_type res;
      int lv, y_db, o_db, r_db, x, yy, m;
      lv   = int'(px.level_db);
      y_db = int'(yellow_db);
      o_db = int'(orange_db);
      r_db = int'(red_db);
      res.border = 1'b0;
      if (px.show && int'(px.column) < FRAME_W && int'(px.row) < FRAME_H) begin
         x  = int'(px.column);
         yy = int'(px.row);
         m  = x;
         if (yy < m) m = yy;
         if (FRAME_W - 1 - x < m) m = FRAME_W - 1 - x;
         if (FRAME_H - 1 - yy < m) m = FRAME_H - 1 - yy;
         res.border = (m < int'(band_width));
      end
      // zones are tested in order, thresholds may be unordered or below the ramp length
      if (lv < y_db - 5) res.colour = grey_rgb;
      else if (lv < y_db) res.colour = blend_rgb(grey_rgb, yellow_rgb, lv - (y_db - 5));
      else if (lv < o_db - 5) res.colour = yellow_rgb;
      else if (lv < o_db) res.colour = blend_rgb(yellow_rgb, orange_rgb, lv - (o_db - 5));
      else if (lv < r_db - 5) res.colour = orange_rgb;
      else if (lv < r_db) res.colour = blend_rgb(orange_rgb, red_rgb, lv - (r_db - 5));
      else res.colour = red_rgb;
      if (lv >= y_db && lv < o_db) res.blink = BLINK_SLOW;
      else if (lv >= o_db && lv < r_db) res.blink = BLINK_MEDIUM;
      else if (lv >= r_db) res.blink = BLINK_FAST;
      else res.blink = BLINK_NONE;
      return res;
   endfunction

   function automatic int near_edge(int limit, int band);
      int d;
      d = int'($urandom_range(0, band + 1));
      if (d > limit) d = limit;
      return ($urandom_range(0, 1) != 0) ? d : limit - d;
   endfunction

   function automatic pixel_req_type random_pixel();
      pixel_req_type px;
      int band, t, lv;
      band = int'(band_width);
      if ($urandom_range(0, 1) != 0) px.column = 6'($urandom_range(0, FRAME_W - 1));
      else px.column = 6'(near_edge(FRAME_W - 1, band));
      if ($urandom_range(0, 1) != 0) px.row = 5'($urandom_range(0, FRAME_H - 1));
      else px.row = 5'(near_edge(FRAME_H - 1, band));
      if ($urandom_range(0, 1) != 0) begin
         lv = int'($urandom_range(0, 127));
      end else begin
         // cluster around a threshold to walk the blend ramps
         case ($urandom_range(0, 2))
            0: t = int'(yellow_db);
            1: t = int'(orange_db);
            default: t = int'(red_db);
         endcase
         lv = t - 6 + int'($urandom_range(0, 7));
         if (lv < 0) lv = 0;
         if (lv > 127) lv = 127;
      end
      px.level_db = 7'(lv);
      px.show = ($urandom_range(0, 99) < 80);
      return px;
   endfunction

   function automatic void apply_reg(reg_index_type idx, logic [CSR_W-1:0] data);
      case (idx)
         REG_YELLOW_LEVEL:  yellow_db  = data[LEVEL_W-1:0];
         REG_ORANGE_LEVEL:  orange_db  = data[LEVEL_W-1:0];
         REG_RED_LEVEL:     red_db     = data[LEVEL_W-1:0];
         REG_GREY_COLOUR:   grey_rgb   = data[COLOUR_W-1:0];
         REG_YELLOW_COLOUR: yellow_rgb = data[COLOUR_W-1:0];
         REG_ORANGE_COLOUR: orange_rgb = data[COLOUR_W-1:0];
         REG_RED_COLOUR:    red_rgb    = data[COLOUR_W-1:0];
         REG_BORDER_WIDTH: begin
            // zero thickness is refused
            if (data[BORDER_W-1:0] != '0) band_width = data[BORDER_W-1:0];
         end
         default: ;
      endcase
   endfunction

   task automatic load_regs();
      for (int i = 0; i < NUM_REGS; i++) begin
         csr_write <= 1'b1;
         csr_index <= reg_index_type'(i);
         csr_data  <= reg_image[i];
         @(posedge clock);
         apply_reg(reg_index_type'(i), reg_image[i]);
      end
      csr_write <= 1'b0;
   endtask

   task automatic send_pixel(pixel_req_type px, pixel_result_type want);
      if (!steady) begin
         while ($urandom_range(0, 99) < IDLE_PERCENT) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid    <= 1'b1;
      req_column   <= px.column;
      req_row      <= px.row;
      req_level_db <= px.level_db;
      req_show     <= px.show;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_pixels.push_back(want);
   endtask

   task automatic check_pixel();
      pixel_result_type want;
      if (expected_pixels.size() == 0) begin
         $error("result with no request outstanding");
         mismatch_count++;
         return;
      end
      want = expected_pixels.pop_front();
      if (rsp_border_pixel !== want.border) begin
         $error("border_pixel: expected %0d, got %0d", want.border, rsp_border_pixel);
         mismatch_count++;
      end
      if (rsp_red !== want.colour.red) begin
         $error("red: expected %0d, got %0d", want.colour.red, rsp_red);
         mismatch_count++;
      end
      if (rsp_green !== want.colour.green) begin
         $error("green: expected %0d, got %0d", want.colour.green, rsp_green);
         mismatch_count++;
      end
      if (rsp_blue !== want.colour.blue) begin
         $error("blue: expected %0d, got %0d", want.colour.blue, rsp_blue);
         mismatch_count++;
      end
      if (rsp_blink_speed !== want.blink) begin
         $error("blink_speed: expected %0d, got %0d", want.blink, rsp_blink_speed);
         mismatch_count++;
      end
   endtask

   // result side: check on each accepted result, then pick the next stall
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) check_pixel();
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= (!steady && $urandom_range(0, 99) < IDLE_PERCENT);
         end
      end
   end

   initial begin
      pixel_req_type px;
      int y_db, o_db;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_pixel(directed_rows[i].px,
                    directed_rows[i].typed ? directed_rows[i].want
                                           : predict_pixel(directed_rows[i].px));

      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase != 0) begin
            while (expected_pixels.size() != 0) @(posedge clock);
            case (phase)
               // thresholds under the ramp length, black and white, widest normal band
               1: reg_image = '{24'd0, 24'd1, 24'd2, 24'h000000, 24'hFFFFFF,
                                24'h000000, 24'hFFFFFF, 24'd16};
               // all bits set except the yellow and red colours: levels mask to 127, band to 31
               2: reg_image = '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                                24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF};
               // descending thresholds; band write masks to zero and is dropped
               3: reg_image = '{24'd100, 24'd60, 24'd20, 24'($urandom()),
                                24'($urandom()), 24'($urandom()), 24'($urandom()),
                                24'hFFFFE0};
               4, 5: begin
                  y_db = int'($urandom_range(5, 110));
                  o_db = y_db + int'($urandom_range(0, 10));
                  reg_image[REG_YELLOW_LEVEL] = 24'(y_db);
                  reg_image[REG_ORANGE_LEVEL] = 24'(o_db);
                  reg_image[REG_RED_LEVEL]    = 24'(o_db + int'($urandom_range(0, 7)));
                  for (int i = REG_GREY_COLOUR; i <= REG_RED_COLOUR; i++)
                     reg_image[i] = 24'($urandom());
                  reg_image[REG_BORDER_WIDTH] = 24'($urandom_range(1, 16));
               end
               default: begin
                  for (int i = 0; i < NUM_REGS; i++) reg_image[i] = 24'($urandom());
               end
            endcase
            load_regs();
         end
         steady = (phase == 4);
         // long result hold-off so the input side backs up
         if (phase == 5) hold_pending = 1'b1;
         repeat (PIXELS_PER_PHASE) begin
            px = random_pixel();
            send_pixel(px, predict_pixel(px));
         end
         req_valid <= 1'b0;
      end

      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("level_border_colour_overlay_tb: clean");
      end else begin
         $display("level_border_colour_overlay_tb: errors");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("level_border_colour_overlay_tb: errors");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/lbco_pkg.sv
hdl/level_border_colour_overlay.sv
hdl/lbco_checker.sv
dv/level_border_colour_overlay_tb.sv
